// File: hw/rtl/pss_pkg.sv
// pss_pkg: shared types and constants of the positional sequence store.
// Used by pss_cell, pss_ctrl and positional_sequence_store_top.
package pss_pkg;

  localparam int unsigned CAPACITY_DEF = 1024;
  localparam int unsigned POS_W        = 11;
  localparam int unsigned VAL_W        = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_ERASE  = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  typedef struct packed {
    op_t                     op;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic [POS_W-1:0]        length;
    status_t                 status;
  } rsp_t;

  // per-cycle command broadcast along the cell row
  typedef struct packed {
    logic                    ins;
    logic                    ers;
    logic                    snap;
    logic                    rshift;
    logic signed [VAL_W-1:0] value;
  } cell_ctl_t;

endpackage

// File: hw/rtl/positional_sequence_store_top.sv
// positional_sequence_store_top: ordered store of up to CAPACITY signed values.
// Depends on pss_pkg, pss_ctrl and pss_cell.
//
// Request channel req_valid / req_stall / req carries op, position and value;
// a transfer happens on a rising edge with valid high and stall low. The
// response channel rsp_valid / rsp_stall / rsp returns one result per request:
// read_value, length after the operation and status.
// Storage is a row of CAPACITY cells, one element each. Insert and erase move
// every element from the position onward by one cell, all at the same edge.
// Insert, erase, clear and any rejected request load their result into the
// response register at the transfer edge; while rsp_stall stays low a new request
// can transfer on the next edge, so these run at one request per cycle.
// A read of position p copies the row into a read-out line that shifts one cell
// a cycle towards cell 0, p times, until the element reaches the head. No request
// is taken during a read-out.
// Reset clears the length and the control; element contents stay undefined
// and need no clearing pass. While rsp_stall is high the response holds and
// req_stall rises until the waiting response is taken.
module positional_sequence_store_top
  import pss_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int unsigned CAP_W = $clog2(CAPACITY + 1);
  localparam int unsigned CW    = (CAP_W > POS_W) ? CAP_W : POS_W;

  cell_ctl_t               ctl;
  logic [CW-1:0]           pos_x;
  logic signed [VAL_W-1:0] data_w [CAPACITY];
  logic signed [VAL_W-1:0] rd_w   [CAPACITY];

  assign pos_x = CW'(req.position);

  pss_ctrl #(
    .CAPACITY(CAPACITY),
    .CW      (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp),
    .head_rd  (rd_w[0]),
    .ctl      (ctl)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_data;
    logic signed [VAL_W-1:0] right_data;
    logic signed [VAL_W-1:0] right_rd;

    if (i == 0) begin : g_first
      assign left_data = '0;
    end else begin : g_inner_l
      assign left_data = data_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_data = '0;
      assign right_rd   = '0;
    end else begin : g_inner_r
      assign right_data = data_w[i+1];
      assign right_rd   = rd_w[i+1];
    end

    pss_cell #(
      .INDEX(i),
      .PW   (CW)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .pos       (pos_x),
      .left_data (left_data),
      .right_data(right_data),
      .right_rd  (right_rd),
      .data      (data_w[i]),
      .rd        (rd_w[i])
    );
  end

endmodule

// File: hw/rtl/pss_cell.sv
// pss_cell: one storage slot of the sequence, plus one stage of the read-out line.
// Depends on pss_pkg.
module pss_cell
  import pss_pkg::*;
#(
  parameter int unsigned INDEX = 0,
  parameter int unsigned PW    = POS_W
) (
  input  logic                    clk,
  input  cell_ctl_t               ctl,
  input  logic [PW-1:0]           pos,
  input  logic signed [VAL_W-1:0] left_data,
  input  logic signed [VAL_W-1:0] right_data,
  input  logic signed [VAL_W-1:0] right_rd,
  output logic signed [VAL_W-1:0] data,
  output logic signed [VAL_W-1:0] rd
);

  localparam logic [PW-1:0] IDX = PW'(INDEX);

  logic signed [VAL_W-1:0] data_next;
  logic signed [VAL_W-1:0] rd_next;

  always_comb begin
    data_next = data;
    if (ctl.ins) begin
      if (IDX > pos) begin
        data_next = left_data;
      end else if (IDX == pos) begin
        data_next = ctl.value;
      end
    end else if (ctl.ers && (IDX >= pos)) begin
      data_next = right_data;
    end
  end

  always_comb begin
    rd_next = rd;
    if (ctl.snap) begin
      rd_next = data;
    end else if (ctl.rshift) begin
      rd_next = right_rd;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
    rd   <= rd_next;
  end

endmodule

// File: hw/rtl/pss_ctrl.sv
// pss_ctrl: length count, operation decode, read sequencing and result register.
// Depends on pss_pkg; drives the command of the pss_cell row.
module pss_ctrl
  import pss_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  parameter int unsigned CW       = POS_W
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_stall,
  input  req_t                    req,
  output logic                    rsp_valid,
  input  logic                    rsp_stall,
  output rsp_t                    rsp,
  input  logic signed [VAL_W-1:0] head_rd,
  output cell_ctl_t               ctl
);

  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] rcnt, rcnt_next;
  logic          rsp_valid_next;
  rsp_t          rsp_next;
  logic [CW-1:0] pos_x;
  logic          out_free;
  logic          take;

  assign pos_x    = CW'(req.position);
  assign out_free = !rsp_valid || !rsp_stall;
  assign take     = req_valid && !req_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (take && (req.op == OP_READ) && (pos_x < count)) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        if ((rcnt == '0) && out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl            = '0;
    ctl.value      = req.value;
    count_next     = count;
    rcnt_next      = rcnt;
    rsp_valid_next = rsp_valid && rsp_stall;
    rsp_next       = rsp;
    req_stall      = 1'b1;
    unique case (state)
      S_IDLE: begin
        req_stall = !out_free;
        if (take) begin
          rsp_valid_next = 1'b1;
          rsp_next       = '{read_value: '0, length: '0, status: ST_OK};
          unique case (req.op)
            OP_INSERT: begin
              if (count >= CAP) begin
                rsp_next.status = ST_FULL;
              end else if (pos_x > count) begin
                rsp_next.status = ST_RANGE;
              end else begin
                ctl.ins    = 1'b1;
                count_next = count + 1'b1;
              end
            end
            OP_ERASE: begin
              if (pos_x >= count) begin
                rsp_next.status = ST_RANGE;
              end else begin
                ctl.ers    = 1'b1;
                count_next = count - 1'b1;
              end
            end
            OP_READ: begin
              if (pos_x >= count) begin
                rsp_next.status = ST_RANGE;
              end else begin
                ctl.snap       = 1'b1;
                rcnt_next      = pos_x;
                rsp_valid_next = rsp_valid && rsp_stall;
                rsp_next       = rsp;
              end
            end
            OP_CLEAR: count_next = '0;
            default: ;
          endcase
          if (rsp_valid_next && !(rsp_valid && rsp_stall)) begin
            rsp_next.length = count_next[POS_W-1:0];
          end
        end
      end
      S_READ: begin
        if (rcnt != '0) begin
          ctl.rshift = 1'b1;
          rcnt_next  = rcnt - 1'b1;
        end else if (out_free) begin
          rsp_valid_next = 1'b1;
          rsp_next       = '{read_value: head_rd, length: count[POS_W-1:0], status: ST_OK};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rcnt      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rcnt      <= rcnt_next;
      rsp_valid <= rsp_valid_next;
    end
    rsp <= rsp_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CAP)
    else $error("length count above capacity");

  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> req_stall)
    else $error("transfer possible during read-out");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    (take && (req.op == OP_CLEAR)) |=> (count == '0))
    else $error("clear did not empty the store");

  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (take && (req.op == OP_INSERT) && (count >= CAP)) |=> $stable(count))
    else $error("insert into full store changed length");

  a_idle_rcnt: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (rcnt == '0))
    else $error("read-out counter left non-zero");

endmodule

// File: tb/sv/tb_positional_sequence_store_top.sv
`timescale 1ns / 100ps
// tb_positional_sequence_store_top: self-checking bench for the positional sequence store.
// Depends on pss_pkg and positional_sequence_store_top; a queue-based model predicts each
// response, with random gaps on both channels and a run that fills the store to capacity.

module tb_positional_sequence_store_top;
  import pss_pkg::*;

  localparam int unsigned CAP         = CAPACITY_DEF;
  localparam int unsigned MAX_GAP     = 13;
  localparam int unsigned CYCLE_LIMIT = 8000000;

  class seq_scoreboard;
    logic signed [VAL_W-1:0] contents[$];
    rsp_t                    outcomes_due[$];
    int unsigned             mismatches;
    int unsigned             requests;
    int unsigned             checked;
    int unsigned             full_refusals;

    function new();
      mismatches    = 0;
      requests      = 0;
      checked       = 0;
      full_refusals = 0;
    endfunction

    function int unsigned depth();
      return contents.size();
    endfunction

    function int unsigned outstanding();
      return outcomes_due.size();
    endfunction

    // applies one request to the sequence copy and returns the response it should give
    function rsp_t predict_outcome(req_t r);
      rsp_t        e;
      int unsigned n;
      n = contents.size();
      e = '0;
      e.status = ST_OK;
      case (r.op)
        OP_INSERT: begin
          if (n >= CAP) e.status = ST_FULL;
          else if (r.position > n) e.status = ST_RANGE;
          else contents.insert(r.position, r.value);
        end
        OP_ERASE: begin
          if (r.position >= n) e.status = ST_RANGE;
          else contents.delete(r.position);
        end
        OP_READ: begin
          if (r.position >= n) e.status = ST_RANGE;
          else e.read_value = contents[r.position];
        end
        default: contents.delete();
      endcase
      e.length = POS_W'(contents.size());
      return e;
    endfunction

    function void note_request(req_t r);
      requests++;
      outcomes_due.push_back(predict_outcome(r));
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("MISMATCH at %0t: %s", $time, what);
    endtask

    task check_response(rsp_t got);
      rsp_t want;
      if (outcomes_due.size() == 0) begin
        report_mismatch("response with no request outstanding");
        return;
      end
      want = outcomes_due.pop_front();
      checked++;
      if (want.status == ST_FULL) full_refusals++;
      if (got.read_value !== want.read_value)
        report_mismatch($sformatf("read_value %0d, want %0d", got.read_value, want.read_value));
      if (got.length !== want.length)
        report_mismatch($sformatf("length %0d, want %0d", got.length, want.length));
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
    endtask
  endclass

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_stall;
  req_t          req       = '0;
  logic          rsp_valid;
  logic          rsp_stall = 1'b0;
  rsp_t          rsp;
  bit            steady    = 1'b0;
  int unsigned   cycles    = 0;
  seq_scoreboard sb        = new();

  positional_sequence_store_top uut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("positional_sequence_store_top verification failed");
      $finish;
    end
  end

  function automatic int unsigned draw_wait();
    return steady ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // response side: take a transfer, then hold stall for a gap drawn by draw_wait
  initial begin : response_side
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) begin
        sb.check_response(rsp);
        hold = draw_wait();
      end
      @(negedge clk);
      rsp_stall <= (hold != 0);
      if (hold != 0) hold--;
    end
  end

  // entered and left at a falling edge
  task automatic send_item(req_t r);
    int unsigned gap;
    gap = draw_wait();
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    sb.note_request(r);
    @(negedge clk);
  endtask

  task automatic send_op(op_t op, int unsigned pos, logic [VAL_W-1:0] val);
    req_t r;
    r.op       = op;
    r.position = pos[POS_W-1:0];
    r.value    = val;
    send_item(r);
  endtask

  task automatic quiesce();
    req_valid <= 1'b0;
    do @(negedge clk); while (sb.outstanding() != 0);
  endtask

  // well-formed positions for the chosen op, plus a share of arbitrary requests
  task automatic send_random(int unsigned ins_w, int unsigned ers_w, int unsigned rd_w,
                             int unsigned clr_w, int unsigned noise_w);
    req_t        r;
    int unsigned n;
    int unsigned pick;
    n          = sb.depth();
    pick       = $urandom_range(0, ins_w + ers_w + rd_w + clr_w + noise_w - 1);
    r.value    = $urandom();
    r.op       = OP_INSERT;
    r.position = POS_W'($urandom_range(0, n));
    if (pick >= ins_w + ers_w + rd_w + clr_w) begin
      r.op       = op_t'($urandom_range(0, (clr_w != 0) ? 3 : 2));
      r.position = POS_W'($urandom_range(0, 2047));
    end else if (pick >= ins_w + ers_w + rd_w) begin
      r.op = OP_CLEAR;
    end else if (pick >= ins_w && n != 0) begin
      r.op       = (pick >= ins_w + ers_w) ? OP_READ : OP_ERASE;
      r.position = POS_W'($urandom_range(0, n - 1));
    end
    send_item(r);
    if ($urandom_range(0, 49) == 0) steady = !steady;
  endtask

  initial begin : request_side
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // empty store, edge values, front / middle / end positions
    send_op(OP_READ, 0, '0);
    send_op(OP_ERASE, 0, '0);
    send_op(OP_INSERT, 1, 32'h1234_5678);
    send_op(OP_INSERT, 0, 32'h7FFF_FFFF);
    send_op(OP_INSERT, 0, 32'h8000_0000);
    send_op(OP_INSERT, 2, 32'hFFFF_FFFF);
    send_op(OP_INSERT, 1, 32'h0000_0000);
    send_op(OP_READ, 0, '0);
    send_op(OP_READ, 1, '0);
    send_op(OP_READ, 2, '0);
    send_op(OP_READ, 3, '0);
    send_op(OP_READ, 4, 32'hFFFF_FFFF);
    send_op(OP_READ, 2047, '0);
    send_op(OP_INSERT, 2047, 32'h5555_5555);
    send_op(OP_ERASE, 2047, 32'hAAAA_AAAA);
    send_op(OP_ERASE, 1, '0);
    send_op(OP_ERASE, 2, '0);
    send_op(OP_READ, 0, '0);
    send_op(OP_READ, 1, '0);
    send_op(OP_CLEAR, 0, '0);
    send_op(OP_READ, 0, '0);
    send_op(OP_CLEAR, 2047, 32'hFFFF_FFFF);
    quiesce();

    repeat (60) send_random(40, 25, 25, 3, 7);
    quiesce();

    // grow to capacity; no clears on the way
    while (sb.depth() < CAP) send_random(96, 1, 2, 0, 1);
    steady = 1'b0;

    send_op(OP_INSERT, 0, $urandom());
    send_op(OP_INSERT, CAP, $urandom());
    send_op(OP_INSERT, 2047, $urandom());
    send_op(OP_READ, CAP - 1, '0);
    send_op(OP_READ, CAP, '0);
    send_op(OP_ERASE, CAP - 1, '0);
    send_op(OP_INSERT, CAP, $urandom());
    send_op(OP_INSERT, CAP - 1, 32'h8000_0000);
    send_op(OP_ERASE, 0, '0);
    send_op(OP_INSERT, 0, 32'h7FFF_FFFF);
    send_op(OP_READ, 0, '0);
    send_op(OP_READ, CAP - 1, '0);
    send_op(OP_INSERT, CAP / 2, $urandom());
    quiesce();

    send_op(OP_CLEAR, 0, '0);
    repeat (20) send_random(40, 25, 25, 3, 7);
    steady = 1'b0;
    quiesce();
    repeat (8) @(posedge clk);

    $display("Covered %0d requests and %0d responses, %0d refused on a full store,",
             sb.requests, sb.checked, sb.full_refusals);
    $display("filling the store to %0d entries and clearing it again.", CAP);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("positional_sequence_store_top verification clean");
    end else begin
      $display("positional_sequence_store_top verification failed");
    end
    $finish;
  end

endmodule
